// ===== hdl/rrsp_pkg.sv =====
package rrsp_pkg;

  // result kinds
  localparam logic [1:0] KIND_LABEL  = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_TRUNC  = 2'd2;

  // bit positions inside record bytes and words
  localparam int MORE_BIT    = 22;
  localparam int ONE_WAY_BIT = 1;
  localparam int NOD2_BIT    = 6;
  localparam int TOLL_BIT    = 7;

  // queue between parser and output side
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);
  localparam logic [Q_CW-1:0] Q_FULL = Q_CW'(Q_DEPTH);

  // everything one byte produces: an optional label and an optional record
  typedef struct packed {
    logic        has_label;
    logic        has_rec;
    logic [1:0]  rec_kind;
    logic [21:0] label;
    logic [31:0] rec_start;
    logic [7:0]  flags;
    logic [23:0] length;
    logic [7:0]  cls;
    logic        nod;
    logic [31:0] nod_val;
  } entry_t;

endpackage

// ===== hdl/rrsp_front.sv =====
module rrsp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                section_start,
  input  logic                q_full,
  output logic                push,
  output rrsp_pkg::entry_t    push_entry
);

  typedef enum logic [8:0] {
    PH_WAIT   = 9'b000000001,
    PH_LABEL  = 9'b000000010,
    PH_FLAGS  = 9'b000000100,
    PH_LEN    = 9'b000001000,
    PH_CLASS  = 9'b000010000,
    PH_LEVEL  = 9'b000100000,
    PH_SKIP   = 9'b001000000,
    PH_NODIND = 9'b010000000,
    PH_NODOFF = 9'b100000000
  } phase_t;

  logic [31:0] section_size;
  logic [31:0] pos, pos_next;
  logic [31:0] rec_start, rec_start_next;
  phase_t      phase, phase_next;
  logic [1:0]  bif, bif_next;
  logic [31:0] acc, acc_next;
  logic [7:0]  flags, flags_next;
  logic [23:0] len, len_next;
  logic [7:0]  cls, cls_next;
  logic [5:0]  skip, skip_next;
  logic [2:0]  nodcnt, nodcnt_next;

  logic        accept;
  logic [31:0] p;
  phase_t      ph, ph_w;
  logic        in_sec, last_byte;
  logic [31:0] room;
  logic [31:0] acc_w, acc_or;
  logic [1:0]  bif_w, bif_inc;
  logic [5:0]  skip_dec, skip_lvl;
  logic [2:0]  nod_dec;
  logic        lab_en, rec_en, rec_nod;
  logic [1:0]  rec_kind;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    p         = section_start ? '0 : pos;
    ph        = section_start ? PH_WAIT : phase;
    in_sec    = p < section_size;
    last_byte = ({1'b0, p} + 33'd1) == {1'b0, section_size};
    room      = section_size - p;

    pos_next       = pos;
    rec_start_next = rec_start;
    phase_next     = phase;
    bif_next       = bif;
    acc_next       = acc;
    flags_next     = flags;
    len_next       = len;
    cls_next       = cls;
    skip_next      = skip;
    nodcnt_next    = nodcnt;
    lab_en         = 1'b0;
    rec_en         = 1'b0;
    rec_kind       = rrsp_pkg::KIND_RECORD;
    rec_nod        = 1'b0;

    ph_w  = ph;
    acc_w = acc;
    bif_w = bif;
    if (ph == PH_WAIT && (|room[31:2])) begin
      ph_w  = PH_LABEL;
      acc_w = '0;
      bif_w = '0;
    end
    acc_or   = acc_w | ({24'b0, data_byte} << {bif_w, 3'b000});
    bif_inc  = bif_w + 2'd1;
    skip_dec = skip - {5'b0, (skip != 6'd0)};
    skip_lvl = {1'b0, data_byte[7:4], 1'b0} + {2'b0, data_byte[7:4]};
    nod_dec  = nodcnt - {2'b0, (nodcnt != 3'd0)};

    if (accept) begin
      pos_next   = (&p) ? p : p + 32'd1;
      phase_next = ph;
      if (in_sec) begin
        if (ph_w == PH_LABEL && ph == PH_WAIT) begin
          rec_start_next = p;
        end
        phase_next = ph_w;
        acc_next   = acc_w;
        bif_next   = bif_w;
        case (ph_w)
          PH_LABEL, PH_LEN: begin
            acc_next = acc_or;
            bif_next = bif_inc;
            if (bif_inc == 2'd3) begin
              acc_next = '0;
              bif_next = '0;
              if (ph_w == PH_LABEL) begin
                lab_en     = |acc_or[21:0];
                phase_next = acc_or[rrsp_pkg::MORE_BIT] ? PH_LABEL : PH_FLAGS;
              end else begin
                len_next   = acc_or[23:0];
                phase_next = PH_CLASS;
              end
            end
          end
          PH_FLAGS: begin
            flags_next = data_byte;
            phase_next = PH_LEN;
            acc_next   = '0;
            bif_next   = '0;
          end
          PH_CLASS: begin
            cls_next   = data_byte;
            phase_next = PH_LEVEL;
          end
          PH_LEVEL, PH_SKIP: begin
            skip_next = (ph_w == PH_LEVEL) ? skip_lvl : skip_dec;
            if (skip_next != 6'd0) begin
              phase_next = PH_SKIP;
            end else if (flags[rrsp_pkg::NOD2_BIT]) begin
              phase_next = PH_NODIND;
            end else begin
              phase_next = PH_WAIT;
              rec_en     = 1'b1;
            end
          end
          PH_NODIND: begin
            nodcnt_next = {1'b0, data_byte[1:0]} + 3'd1;
            phase_next  = PH_NODOFF;
            acc_next    = '0;
            bif_next    = '0;
          end
          PH_NODOFF: begin
            acc_next    = acc_or;
            bif_next    = bif_inc;
            nodcnt_next = nod_dec;
            if (nod_dec == 3'd0) begin
              phase_next = PH_WAIT;
              rec_en     = 1'b1;
              rec_nod    = 1'b1;
            end
          end
          default: begin
          end
        endcase

        // section ends with a record still open
        if (last_byte && phase_next != PH_WAIT) begin
          rec_en = 1'b1;
          if (phase_next == PH_LABEL || phase_next == PH_FLAGS || phase_next == PH_LEN ||
              phase_next == PH_CLASS || phase_next == PH_LEVEL) begin
            rec_kind = rrsp_pkg::KIND_TRUNC;
          end
          phase_next = PH_WAIT;
        end
      end
    end
  end

  assign push                 = accept && (lab_en || rec_en);
  assign push_entry.has_label = lab_en;
  assign push_entry.has_rec   = rec_en;
  assign push_entry.rec_kind  = rec_kind;
  assign push_entry.label     = acc_or[21:0];
  assign push_entry.rec_start = rec_start_next;
  assign push_entry.flags     = flags;
  assign push_entry.length    = len;
  assign push_entry.cls       = cls;
  assign push_entry.nod       = rec_nod;
  assign push_entry.nod_val   = rec_nod ? acc_or : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      section_size <= '0;
      pos          <= '0;
      rec_start    <= '0;
      phase        <= PH_WAIT;
      bif          <= '0;
      acc          <= '0;
      flags        <= '0;
      len          <= '0;
      cls          <= '0;
      skip         <= '0;
      nodcnt       <= '0;
    end else begin
      if (cfg_we) begin
        section_size <= cfg_wdata;
      end
      pos       <= pos_next;
      rec_start <= rec_start_next;
      phase     <= phase_next;
      bif       <= bif_next;
      acc       <= acc_next;
      flags     <= flags_next;
      len       <= len_next;
      cls       <= cls_next;
      skip      <= skip_next;
      nodcnt    <= nodcnt_next;
    end
  end

`ifndef SYNTHESIS
  // a byte past the section end must never produce an item
  a_no_push_out_of_section: assert property (@(posedge clk) disable iff (rst)
    push |-> in_sec)
    else $error("push for a byte outside the section");
`endif

endmodule

// ===== hdl/rrsp_queue.sv =====
module rrsp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rrsp_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output rrsp_pkg::entry_t head
);

  rrsp_pkg::entry_t             mem [rrsp_pkg::Q_DEPTH];
  logic [rrsp_pkg::Q_AW-1:0]    wr_ptr, rd_ptr;
  logic [rrsp_pkg::Q_CW-1:0]    count;

  assign full  = count == rrsp_pkg::Q_FULL;
  assign valid = count != '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rrsp_pkg::Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + rrsp_pkg::Q_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + rrsp_pkg::Q_CW'(1);
        2'b01:   count <= count - rrsp_pkg::Q_CW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= rrsp_pkg::Q_FULL)
    else $error("queue count beyond depth");
`endif

endmodule

// ===== hdl/rrsp_back.sv =====
module rrsp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  rrsp_pkg::entry_t q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       kind,
  output logic [31:0]      record_offset,
  output logic [21:0]      label_offset,
  output logic [7:0]       flags_byte,
  output logic             one_way,
  output logic [23:0]      length_units,
  output logic [2:0]       road_class,
  output logic [2:0]       speed_class,
  output logic             toll,
  output logic             has_nod2,
  output logic [31:0]      nod2_offset,
  output logic             last
);

  rrsp_pkg::entry_t cur;
  logic             pend_label, pend_rec;
  logic             full_rec, taken;

  assign out_valid = pend_label || pend_rec;
  assign last      = !(pend_label && pend_rec);
  assign taken     = out_valid && out_ready;
  // load the next entry once the current one has handed out its final item
  assign pop       = q_valid && (!out_valid || (out_ready && last));

  assign full_rec      = !pend_label && cur.rec_kind == rrsp_pkg::KIND_RECORD;
  assign kind          = pend_label ? rrsp_pkg::KIND_LABEL : cur.rec_kind;
  assign record_offset = cur.rec_start;
  assign label_offset  = pend_label ? cur.label : '0;
  assign flags_byte    = full_rec ? cur.flags : '0;
  assign one_way       = full_rec && cur.flags[rrsp_pkg::ONE_WAY_BIT];
  assign length_units  = full_rec ? cur.length : '0;
  assign road_class    = full_rec ? cur.cls[2:0] : '0;
  assign speed_class   = full_rec ? cur.cls[5:3] : '0;
  assign toll          = full_rec && cur.cls[rrsp_pkg::TOLL_BIT];
  assign has_nod2      = full_rec && cur.nod;
  assign nod2_offset   = (full_rec && cur.nod) ? cur.nod_val : '0;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_label <= 1'b0;
      pend_rec   <= 1'b0;
    end else if (pop) begin
      pend_label <= q_head.has_label;
      pend_rec   <= q_head.has_rec;
    end else if (taken) begin
      if (!last) begin
        pend_label <= 1'b0;
      end else begin
        pend_label <= 1'b0;
        pend_rec   <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // label goes first, its record follows in the next item
  a_label_then_record: assert property (@(posedge clk) disable iff (rst)
    (taken && !last) |=> (out_valid && !pend_label && pend_rec))
    else $error("record lost after label");
`endif

endmodule

// ===== hdl/road_record_stream_parser.sv =====
// Channel   Handshake             Payload
// cfg       cfg_we                cfg_wdata (section_size)
// in        in_valid / in_ready   data_byte, section_start
// out       out_valid / out_ready kind, record_offset, label_offset, record fields, last
//
// One byte per cycle is accepted while the four-entry result queue has room.
// A byte that yields a label and a record hands the label out first, then the record.
// A result passes through the queue, then the output register, before it can be taken.
// Reset (rst, synchronous) clears section_size, parse state and the queue.
// A stalled output fills the queue; in_ready drops only when it is full.
module road_record_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        section_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] record_offset,
  output logic [21:0] label_offset,
  output logic [7:0]  flags_byte,
  output logic        one_way,
  output logic [23:0] length_units,
  output logic [2:0]  road_class,
  output logic [2:0]  speed_class,
  output logic        toll,
  output logic        has_nod2,
  output logic [31:0] nod2_offset,
  output logic        last
);

  rrsp_pkg::entry_t push_entry, q_head;
  logic             push, q_full, q_valid, pop;

  rrsp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .section_start (section_start),
    .q_full        (q_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  rrsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  rrsp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .record_offset (record_offset),
    .label_offset  (label_offset),
    .flags_byte    (flags_byte),
    .one_way       (one_way),
    .length_units  (length_units),
    .road_class    (road_class),
    .speed_class   (speed_class),
    .toll          (toll),
    .has_nod2      (has_nod2),
    .nod2_offset   (nod2_offset),
    .last          (last)
  );

endmodule

// ===== tb/sv/road_record_stream_parser_tb.sv =====
module road_record_stream_parser_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 100;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 10;

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_LABEL     = 9'b000000010,
    ST_FLAGS     = 9'b000000100,
    ST_LENGTH    = 9'b000001000,
    ST_CLASS     = 9'b000010000,
    ST_LEVEL     = 9'b000100000,
    ST_REFS      = 9'b001000000,
    ST_NOD_SIZE  = 9'b010000000,
    ST_NOD_BYTES = 9'b100000000
  } parse_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] roff;
    logic [21:0] lab;
    logic [7:0]  flags;
    logic        one_way;
    logic [23:0] len;
    logic [2:0]  rcls;
    logic [2:0]  spd;
    logic        toll;
    logic        nod;
    logic [31:0] nodv;
    logic        last;
  } road_result_t;

  typedef struct {
    bit          is_cfg;
    logic [31:0] val;
    bit          start;
    int          exp_n;
    logic [1:0]  exp_kind;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        section_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [31:0] record_offset;
  logic [21:0] label_offset;
  logic [7:0]  flags_byte;
  logic        one_way;
  logic [23:0] length_units;
  logic [2:0]  road_class;
  logic [2:0]  speed_class;
  logic        toll;
  logic        has_nod2;
  logic [31:0] nod2_offset;
  logic        last;

  road_record_stream_parser dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .section_start(section_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .record_offset(record_offset), .label_offset(label_offset),
    .flags_byte(flags_byte), .one_way(one_way), .length_units(length_units),
    .road_class(road_class), .speed_class(speed_class), .toll(toll),
    .has_nod2(has_nod2), .nod2_offset(nod2_offset), .last(last)
  );

  // parser mirror
  logic [31:0]  sec_size = '0;
  logic [31:0]  byte_pos = '0;
  logic [31:0]  rec_base = '0;
  parse_state_t pstate = ST_IDLE;
  logic [1:0]   field_cnt = '0;
  logic [31:0]  shift_acc = '0;
  logic [7:0]   flags_r = '0;
  logic [23:0]  length_r = '0;
  logic [7:0]   class_r = '0;
  logic [5:0]   refs_left = '0;
  logic [2:0]   nod_left = '0;

  road_result_t byte_results[$];
  road_result_t road_results_due[$];
  stim_row_t    dir_rows[$];
  logic [7:0]   sec_q[$];

  int err_cnt = 0;
  int n_bytes = 0;
  int n_sections = 0;
  int n_writes = 0;
  int n_checked = 0;
  int kind_seen[4] = '{0, 0, 0, 0};
  int cycles = 0;
  int tx_pct = 0;
  int rx_pct = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  road_result_t exp_r;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still due", $time, cycles,
               road_results_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  task automatic begin_field(input parse_state_t nxt);
    pstate = nxt;
    field_cnt = 2'd0;
    shift_acc = '0;
  endtask

  task automatic push_label(input logic [21:0] lab);
    road_result_t r;
    r = '0;
    r.kind = rrsp_pkg::KIND_LABEL;
    r.roff = rec_base;
    r.lab = lab;
    byte_results.insert(byte_results.size(), r);
  endtask

  task automatic push_record(input logic [1:0] k, input logic nod, input logic [31:0] nv);
    road_result_t r;
    r = '0;
    r.kind = k;
    r.roff = rec_base;
    if (k == rrsp_pkg::KIND_RECORD) begin
      r.flags = flags_r;
      r.one_way = flags_r[rrsp_pkg::ONE_WAY_BIT];
      r.len = length_r;
      r.rcls = class_r[2:0];
      r.spd = class_r[5:3];
      r.toll = class_r[rrsp_pkg::TOLL_BIT];
      r.nod = nod;
      r.nodv = nod ? nv : 32'd0;
    end
    byte_results.insert(byte_results.size(), r);
  endtask

  task automatic refs_done();
    if (flags_r[rrsp_pkg::NOD2_BIT]) begin
      pstate = ST_NOD_SIZE;
    end else begin
      pstate = ST_IDLE;
      push_record(rrsp_pkg::KIND_RECORD, 1'b0, 32'd0);
    end
  endtask

  // Work out the results one accepted byte causes and queue them.
  task automatic parse_byte(input logic [7:0] b, input logic s);
    logic [31:0] p;
    logic [23:0] w;
    byte_results.delete();
    if (s) begin
      byte_pos = '0;
      pstate = ST_IDLE;
    end
    p = byte_pos;
    if (byte_pos != 32'hFFFF_FFFF) byte_pos = byte_pos + 32'd1;
    if (p < sec_size) begin
      if (pstate == ST_IDLE && (sec_size - p) >= 32'd4) begin
        rec_base = p;
        begin_field(ST_LABEL);
      end
      case (pstate)
        ST_LABEL, ST_LENGTH: begin
          shift_acc = shift_acc | (32'(b) << {field_cnt, 3'b000});
          field_cnt = field_cnt + 2'd1;
          if (field_cnt == 2'd3) begin
            w = shift_acc[23:0];
            if (pstate == ST_LABEL) begin
              if (w[21:0] != '0) push_label(w[21:0]);
              begin_field(w[rrsp_pkg::MORE_BIT] ? ST_LABEL : ST_FLAGS);
            end else begin
              length_r = w;
              begin_field(ST_CLASS);
            end
          end
        end
        ST_FLAGS: begin
          flags_r = b;
          begin_field(ST_LENGTH);
        end
        ST_CLASS: begin
          class_r = b;
          pstate = ST_LEVEL;
        end
        ST_LEVEL: begin
          refs_left = 6'(b[7:4]) * 6'd3;
          if (refs_left != '0) pstate = ST_REFS;
          else refs_done();
        end
        ST_REFS: begin
          if (refs_left != '0) refs_left = refs_left - 6'd1;
          if (refs_left == '0) refs_done();
        end
        ST_NOD_SIZE: begin
          nod_left = 3'(b[1:0]) + 3'd1;
          begin_field(ST_NOD_BYTES);
        end
        ST_NOD_BYTES: begin
          shift_acc = shift_acc | (32'(b) << {field_cnt, 3'b000});
          field_cnt = field_cnt + 2'd1;
          if (nod_left != '0) nod_left = nod_left - 3'd1;
          if (nod_left == '0) begin
            pstate = ST_IDLE;
            push_record(rrsp_pkg::KIND_RECORD, 1'b1, shift_acc);
          end
        end
        default: ;
      endcase
      // section ends inside a record: truncated before the level byte, else complete
      if ({1'b0, p} + 33'd1 == {1'b0, sec_size} && pstate != ST_IDLE) begin
        push_record((pstate <= ST_LEVEL) ? rrsp_pkg::KIND_TRUNC : rrsp_pkg::KIND_RECORD,
                    1'b0, 32'd0);
        pstate = ST_IDLE;
      end
    end
    if (byte_results.size() != 0) byte_results[byte_results.size() - 1].last = 1'b1;
    foreach (byte_results[i]) road_results_due.insert(road_results_due.size(), byte_results[i]);
  endtask

  // ---------------------------------------------------------------- sender side
  task automatic send_byte(input logic [7:0] b, input logic s);
    in_valid <= 1'b1;
    data_byte <= b;
    section_start <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_byte(b, s);
    n_bytes++;
  endtask

  task automatic tx_gap();
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drain, let the block settle, then write the section size.
  task automatic write_size(input logic [31:0] v);
    in_valid <= 1'b0;
    while (road_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sec_size = v;
    n_writes++;
  endtask

  task automatic push_le(input logic [31:0] v, input int nb);
    for (int k = 0; k < nb; k++) sec_q.insert(sec_q.size(), v[8*k +: 8]);
  endtask

  task automatic add_record();
    int nlab;
    logic [31:0] w;
    logic [7:0] fl, lv, ind;
    nlab = $urandom_range(1, 3);
    for (int k = 0; k < nlab; k++) begin
      w = $urandom;
      if ($urandom_range(3) == 0) w[21:0] = '0;
      w[rrsp_pkg::MORE_BIT] = (k < nlab - 1);
      push_le(w, 3);
    end
    fl = 8'($urandom);
    push_le(32'(fl), 1);
    push_le($urandom, 3);
    push_le($urandom, 1);
    lv = 8'($urandom);
    lv[7:4] = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(2));
    push_le(32'(lv), 1);
    push_le($urandom, 0);
    for (int k = 0; k < 3 * int'(lv[7:4]); k++) push_le($urandom, 1);
    if (fl[rrsp_pkg::NOD2_BIT]) begin
      ind = 8'($urandom);
      push_le(32'(ind), 1);
      push_le($urandom, int'(ind[1:0]) + 1);
    end
  endtask

  // One section: mostly well-formed records, some cut short, aborted or noise.
  task automatic run_section(input bit busy);
    int mode, total, split, keep;
    logic [31:0] sz;
    sec_q.delete();
    mode = busy ? 0 : $urandom_range(11);
    if (mode == 10) begin
      repeat ($urandom_range(4, 24)) push_le($urandom, 1);
      sz = $urandom_range(0, sec_q.size() + 4);
    end else begin
      repeat (busy ? 6 : $urandom_range(1, 4)) add_record();
      total = sec_q.size();
      case (mode)
        6: sz = $urandom_range(1, total - 1);
        7: begin
          sz = total + $urandom_range(1, 3);
          repeat (int'(sz) - total) push_le($urandom, 1);
        end
        8: begin
          // drop the tail; the next section start cuts in mid-record
          sz = total;
          keep = $urandom_range(1, total - 1);
          while (sec_q.size() > keep) void'(sec_q.pop_back());
        end
        9: sz = 32'hFFFF_FFFF;
        11: begin
          sz = total;
          repeat ($urandom_range(1, 3)) push_le($urandom, 1);
        end
        default: sz = total;
      endcase
    end
    split = (sec_q.size() > 1 && $urandom_range(5) == 0) ? $urandom_range(1, sec_q.size() - 1)
                                                          : -1;
    write_size(sz);
    if (busy) hold_asks++;
    n_sections++;
    for (int k = 0; k < sec_q.size(); k++) begin
      if (k == split) write_size($urandom_range(k, sec_q.size() + 3));
      send_byte(sec_q[k], k == 0);
      tx_gap();
    end
  endtask

  task automatic add_row(input bit c, input logic [31:0] v, input bit s, input int n,
                         input logic [1:0] k);
    stim_row_t r;
    r.is_cfg = c;
    r.val = v;
    r.start = s;
    r.exp_n = n;
    r.exp_kind = k;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // ---------------------------------------------------------------- receiver side
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_asks;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_pct);
    end
  end

  task automatic cmp_field(input string nm, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, nm, e, a);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (road_results_due.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual kind %0d offset 0x%0h",
                 $time, kind, record_offset);
      end else begin
        exp_r = road_results_due.pop_front();
        cmp_field("kind", 32'(exp_r.kind), 32'(kind));
        cmp_field("record_offset", exp_r.roff, record_offset);
        cmp_field("label_offset", 32'(exp_r.lab), 32'(label_offset));
        cmp_field("flags_byte", 32'(exp_r.flags), 32'(flags_byte));
        cmp_field("one_way", 32'(exp_r.one_way), 32'(one_way));
        cmp_field("length_units", 32'(exp_r.len), 32'(length_units));
        cmp_field("road_class", 32'(exp_r.rcls), 32'(road_class));
        cmp_field("speed_class", 32'(exp_r.spd), 32'(speed_class));
        cmp_field("toll", 32'(exp_r.toll), 32'(toll));
        cmp_field("has_nod2", 32'(exp_r.nod), 32'(has_nod2));
        cmp_field("nod2_offset", exp_r.nodv, nod2_offset);
        cmp_field("last", 32'(exp_r.last), 32'(last));
        n_checked++;
        kind_seen[kind]++;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    // byte with size still zero after reset: ignored
    add_row(1'b0, 32'hFF, 1'b1, 0, rrsp_pkg::KIND_LABEL);
    // full record: max label, one-way, max length, toll, three refs, 4-byte NOD2 at end
    add_row(1'b1, 32'd17, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'hFF, 1'b1, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'hFF, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'h3F, 1'b0, 1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'h42, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'hFF, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'hFF, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'hFF, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'hBF, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'h10, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'h00, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'hAA, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'h55, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'h03, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'hFF, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'hFF, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'hFF, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'hFF, 1'b0, 1, rrsp_pkg::KIND_RECORD);
    // chained label, size grows mid-section, label completes on the last byte
    add_row(1'b1, 32'd4, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'h01, 1'b1, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'h00, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'h40, 1'b0, 1, rrsp_pkg::KIND_LABEL);
    add_row(1'b1, 32'd6, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'h02, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'h00, 1'b0, -1, rrsp_pkg::KIND_LABEL);
    add_row(1'b0, 32'h00, 1'b0, 2, rrsp_pkg::KIND_TRUNC);
    // past the section end: ignored
    add_row(1'b0, 32'h77, 1'b0, 0, rrsp_pkg::KIND_LABEL);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    tx_pct = 35;
    rx_pct = 51;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_size(dir_rows[i].val);
      end else begin
        send_byte(dir_rows[i].val[7:0], dir_rows[i].start);
        if (dir_rows[i].exp_n >= 0 &&
            (byte_results.size() != dir_rows[i].exp_n ||
             (dir_rows[i].exp_n > 0 && byte_results[byte_results.size() - 1].kind !==
                                       dir_rows[i].exp_kind))) begin
          err_cnt++;
          $display("%0t: row %0d, expected %0d results ending in kind %0d, actual %0d",
                   $time, i, dir_rows[i].exp_n, dir_rows[i].exp_kind, byte_results.size());
        end
        tx_gap();
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      int first;
      case (ph)
        0: begin tx_pct = 35; rx_pct = 51; end
        1: begin tx_pct = 51; rx_pct = 35; end
        default: begin tx_pct = 0; rx_pct = 0; end
      endcase
      first = n_bytes;
      // hold the output off while bytes keep coming, so the queue fills
      if (ph == 2) run_section(1'b1);
      while (n_bytes - first < PHASE_BYTES) run_section(1'b0);
    end

    in_valid <= 1'b0;
    while (road_results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d bytes in %0d sections with %0d size writes; %0d results checked",
             n_bytes, n_sections, n_writes, n_checked);
    $display("labels %0d, complete records %0d, truncated records %0d",
             kind_seen[0], kind_seen[1], kind_seen[2]);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
